FILE: rtl/assert_macros.svh
// Assertion macros used by the ARQ sender datapath.
// Assumes a clock named clk and an active-high synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, masked while in reset.
`define SAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SAW_NEVER(lbl, expr, msg) \
  `SAW_ASSERT(lbl, !(expr), msg)

`endif

FILE: rtl/sawarq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stop-and-wait ARQ sender.
// No dependencies; the controller, datapath and top level import this package.
package sawarq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;

  localparam int SEQ_W      = 32;
  localparam int CHK_W      = 32;
  localparam int TIMER_W    = 16;
  localparam int PAY_BYTES  = 20;
  localparam int PAY_W      = 8 * PAY_BYTES;
  localparam int PAY_LO_W   = 64;
  localparam int PAY_MID_W  = 64;
  localparam int PAY_HI_W   = 32;

  // Action codes of an input item.
  localparam logic [1:0] ACT_MSG  = 2'd0;
  localparam logic [1:0] ACT_ACK  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Result status codes.
  localparam logic STATUS_SENT = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  localparam logic [SEQ_W-1:0] ACK_NUM = 32'd1;

  // APB register map.
  localparam int                  APB_DATA_W    = 32;
  localparam int                  PADDR_W       = 3;
  localparam int                  REG_IDX_W     = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = '0;
  localparam logic [TIMER_W-1:0]  TIMEOUT_RESET = 16'd22;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_SEND,
    ST_DROP
  } state_t;

  // Controller -> datapath.
  typedef struct packed {
    logic in_ready;
    logic enqueue;
    logic dequeue;
    logic tmr_start;
    logic tmr_stop;
    logic tmr_dec;
    logic rd_head;
    logic load_pkt;
    logic load_drop;
  } cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic       in_fire;
    logic [1:0] act;
    logic       q_empty;
    logic       q_full;
    logic       q_single;
    logic       ack_ok;
    logic       tmr_run;
    logic       tmr_expire;
    logic       out_free;
  } stat_t;

endpackage

FILE: rtl/sawarq_in_if.sv
`timescale 1ns / 1ps
// Input item channel of the ARQ sender: valid/ready plus message/ack/tick fields.
// Standalone; no package needed.
interface sawarq_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [31:0] ack_seq;
  logic        [31:0] ack_number;
  logic signed [31:0] ack_checksum;
  logic        [63:0] payload_low;
  logic        [63:0] payload_mid;
  logic        [31:0] payload_high;

  modport source (
    output valid, action, ack_seq, ack_number, ack_checksum,
           payload_low, payload_mid, payload_high,
    input  ready
  );

  modport sink (
    input  valid, action, ack_seq, ack_number, ack_checksum,
           payload_low, payload_mid, payload_high,
    output ready
  );
endinterface

FILE: rtl/sawarq_out_if.sv
`timescale 1ns / 1ps
// Result item channel of the ARQ sender: valid/ready plus outgoing packet fields.
// Standalone; no package needed.
interface sawarq_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic        [31:0] out_seq;
  logic        [31:0] out_ack_number;
  logic signed [31:0] out_checksum;
  logic        [63:0] out_payload_low;
  logic        [63:0] out_payload_mid;
  logic        [31:0] out_payload_high;

  modport source (
    output valid, status, out_seq, out_ack_number, out_checksum,
           out_payload_low, out_payload_mid, out_payload_high,
    input  ready
  );

  modport sink (
    input  valid, status, out_seq, out_ack_number, out_checksum,
           out_payload_low, out_payload_mid, out_payload_high,
    output ready
  );
endinterface

FILE: rtl/sawarq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sawarq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sawarq_ctrl.sv
`timescale 1ns / 1ps
// Sequencing FSM of the ARQ sender: decides per item what the datapath does.
// Depends on sawarq_pkg.
module sawarq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  sawarq_pkg::stat_t  stat,
  output sawarq_pkg::cmd_t   cmd
);
  import sawarq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (stat.in_fire) state_next = ST_CALC;
      end
      ST_CALC: begin
        state_next = ST_IDLE;
        unique case (stat.act)
          ACT_MSG: begin
            if (stat.q_full)       state_next = ST_DROP;
            else if (stat.q_empty) state_next = ST_READ;
          end
          ACT_ACK: begin
            if (!stat.q_empty && stat.ack_ok && !stat.q_single) state_next = ST_READ;
          end
          ACT_TICK: begin
            if (stat.tmr_run && stat.tmr_expire && !stat.q_empty) state_next = ST_READ;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_READ: state_next = ST_SEND;
      ST_SEND: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_DROP: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.in_ready = 1'b1;
      ST_CALC: begin
        unique case (stat.act)
          ACT_MSG: begin
            if (!stat.q_full) begin
              cmd.enqueue = 1'b1;
              if (stat.q_empty) cmd.tmr_start = 1'b1;
            end
          end
          ACT_ACK: begin
            if (!stat.q_empty && stat.ack_ok) begin
              cmd.dequeue = 1'b1;
              if (stat.q_single) cmd.tmr_stop  = 1'b1;
              else               cmd.tmr_start = 1'b1;
            end
          end
          ACT_TICK: begin
            if (stat.tmr_run) begin
              if (!stat.tmr_expire)  cmd.tmr_dec   = 1'b1;
              else if (stat.q_empty) cmd.tmr_stop  = 1'b1;
              else                   cmd.tmr_start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_READ: cmd.rd_head   = 1'b1;
      ST_SEND: cmd.load_pkt  = stat.out_free;
      ST_DROP: cmd.load_drop = stat.out_free;
    endcase
  end

endmodule

FILE: rtl/sawarq_dp.sv
`timescale 1ns / 1ps
// Datapath of the ARQ sender: input capture, checksum, packet queue, timer, output register.
// Depends on sawarq_pkg, sawarq_in_if, sawarq_out_if, sawarq_ram, assert_macros.svh.
`include "assert_macros.svh"
module sawarq_dp #(
  parameter int QUEUE_DEPTH = sawarq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  sawarq_in_if.sink                       ingress,
  sawarq_out_if.source                    egress,
  input  logic [sawarq_pkg::TIMER_W-1:0]  timeout,
  input  sawarq_pkg::cmd_t                cmd,
  output sawarq_pkg::stat_t               stat
);
  import sawarq_pkg::*;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W   = CHK_W + PAY_W;
  localparam int SUM_W     = 13;
  localparam int GRP_BYTES = 4;
  localparam int N_GRP     = PAY_BYTES / GRP_BYTES;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // Clear every byte from the first zero byte on.
  function automatic logic [PAY_W-1:0] trim_payload(input logic [PAY_W-1:0] p);
    logic [PAY_BYTES-1:0] zero;
    logic [PAY_BYTES-1:0] upto;
    logic [PAY_W-1:0]     r;
    for (int i = 0; i < PAY_BYTES; i++) begin
      zero[i] = (p[8*i +: 8] == 8'h00);
    end
    for (int i = 0; i < PAY_BYTES; i++) begin
      upto         = PAY_BYTES'((64'd1 << (i + 1)) - 64'd1);
      r[8*i +: 8]  = ((zero & upto) == '0) ? p[8*i +: 8] : 8'h00;
    end
    return r;
  endfunction

  // Sum of the 20 bytes as signed values: groups of four, then the groups.
  function automatic logic signed [SUM_W-1:0] byte_sum(input logic [PAY_W-1:0] p);
    logic signed [SUM_W-1:0] grp [N_GRP];
    logic signed [SUM_W-1:0] total;
    for (int g = 0; g < N_GRP; g++) begin
      grp[g] = '0;
      for (int k = 0; k < GRP_BYTES; k++) begin
        grp[g] = grp[g] + $signed({{(SUM_W-8){p[8*(GRP_BYTES*g+k)+7]}},
                                   p[8*(GRP_BYTES*g+k) +: 8]});
      end
    end
    total = '0;
    for (int g = 0; g < N_GRP; g++) begin
      total = total + grp[g];
    end
    return total;
  endfunction

  // Captured item.
  logic [1:0]        act_r;
  logic [SEQ_W-1:0]  ack_seq_r;
  logic [SEQ_W-1:0]  ack_num_r;
  logic [CHK_W-1:0]  ack_chk_r;
  logic [PAY_W-1:0]  pay_r;
  logic [CHK_W-1:0]  hdr_r;

  // Queue and timer state.
  logic [SEQ_W-1:0]   next_seq;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [TIMER_W-1:0] timer_left;
  logic               timer_run;

  logic               out_valid;
  logic [ENTRY_W-1:0] rd_entry;

  logic [PAY_W-1:0]        in_pay;
  logic signed [SUM_W-1:0] bsum;
  logic [CHK_W-1:0]        chk;
  logic [SEQ_W-1:0]        front_seq;
  logic [PTR_W-1:0]        head_inc;
  logic [PTR_W-1:0]        tail_inc;

  assign in_pay    = {ingress.payload_high, ingress.payload_mid, ingress.payload_low};
  assign bsum      = byte_sum(pay_r);
  assign chk       = hdr_r + {{(CHK_W-SUM_W){bsum[SUM_W-1]}}, bsum};
  assign front_seq = next_seq - SEQ_W'(count);
  assign head_inc  = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
  assign tail_inc  = (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);

  assign ingress.ready = cmd.in_ready;

  always_comb begin
    stat            = '0;
    stat.in_fire    = ingress.valid && ingress.ready;
    stat.act        = act_r;
    stat.q_empty    = (count == '0);
    stat.q_full     = (count == FULL_CNT);
    stat.q_single   = (count == CNT_W'(1));
    stat.ack_ok     = (chk == ack_chk_r) && (ack_num_r == ACK_NUM) && (ack_seq_r == front_seq);
    stat.tmr_run    = timer_run;
    stat.tmr_expire = (timer_left <= TIMER_W'(1));
    stat.out_free   = !out_valid || egress.ready;
  end

  // Item capture; message payloads are trimmed here, ack payloads kept raw.
  always_ff @(posedge clk) begin
    if (stat.in_fire) begin
      act_r     <= ingress.action;
      ack_seq_r <= ingress.ack_seq;
      ack_num_r <= ingress.ack_number;
      ack_chk_r <= ingress.ack_checksum;
      if (ingress.action == ACT_MSG) begin
        pay_r <= trim_payload(in_pay);
        hdr_r <= next_seq + ACK_NUM;
      end else begin
        pay_r <= in_pay;
        hdr_r <= ingress.ack_seq + ingress.ack_number;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_seq <= '0;
      count    <= '0;
      head     <= '0;
      tail     <= '0;
    end else begin
      if (cmd.enqueue) begin
        next_seq <= next_seq + SEQ_W'(1);
        tail     <= tail_inc;
        count    <= count + CNT_W'(1);
      end else if (cmd.dequeue) begin
        head  <= head_inc;
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_left <= '0;
      timer_run  <= 1'b0;
    end else begin
      priority if (cmd.tmr_start) begin
        timer_left <= timeout;
        timer_run  <= 1'b1;
      end else if (cmd.tmr_stop) begin
        timer_left <= '0;
        timer_run  <= 1'b0;
      end else if (cmd.tmr_dec) begin
        timer_left <= timer_left - TIMER_W'(1);
      end
    end
  end

  // Entry layout: checksum on top, then payload bytes 19..0.
  sawarq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.enqueue),
    .waddr (tail),
    .wdata ({chk, pay_r}),
    .re    (cmd.rd_head),
    .raddr (head),
    .rdata (rd_entry)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_pkt || cmd.load_drop) begin
      out_valid <= 1'b1;
    end else if (egress.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      egress.status           <= STATUS_SENT;
      egress.out_seq          <= front_seq;
      egress.out_ack_number   <= ACK_NUM;
      egress.out_checksum     <= rd_entry[PAY_W +: CHK_W];
      egress.out_payload_low  <= rd_entry[0 +: PAY_LO_W];
      egress.out_payload_mid  <= rd_entry[PAY_LO_W +: PAY_MID_W];
      egress.out_payload_high <= rd_entry[PAY_LO_W + PAY_MID_W +: PAY_HI_W];
    end else if (cmd.load_drop) begin
      egress.status           <= STATUS_DROP;
      egress.out_seq          <= '0;
      egress.out_ack_number   <= '0;
      egress.out_checksum     <= '0;
      egress.out_payload_low  <= '0;
      egress.out_payload_mid  <= '0;
      egress.out_payload_high <= '0;
    end
  end

  assign egress.valid = out_valid;

  `SAW_ASSERT(a_enq_not_full, cmd.enqueue |-> !stat.q_full, "enqueue into a full queue")
  `SAW_ASSERT(a_deq_not_empty, cmd.dequeue |-> !stat.q_empty, "dequeue from an empty queue")
  `SAW_ASSERT(a_enq_count, cmd.enqueue |=> (count == $past(count) + CNT_W'(1)), "count missed an enqueue")
  `SAW_NEVER(a_timer_idle_queue, timer_run && (count == '0), "timer running with empty queue")
  `SAW_ASSERT(a_load_free, (cmd.load_pkt || cmd.load_drop) |-> stat.out_free, "output register overwritten")

endmodule

FILE: rtl/stop_and_wait_arq_sender_unit.sv
`timescale 1ns / 1ps
// Top level of the stop-and-wait ARQ sender: APB register, controller and datapath.
// Depends on sawarq_pkg, sawarq_in_if, sawarq_out_if, sawarq_ctrl, sawarq_dp.
//
//   channel   dir   protocol     carries
//   ingress   in    valid/ready  action, ack header fields, 20-byte payload
//   egress    out   valid/ready  status, packet header, checksum, payload
//   apb       in    APB          retransmit_timeout at byte address 0
//
// An item is taken in the idle cycle and resolved in the next one. A send then
// adds a step for the queue RAM read and one to load the output register; a
// drop adds only the step that loads the output register.
// A full output register holds the send/drop step until egress takes it; the
// next item is still accepted once the register has been loaded.
// Reset (rst, synchronous) empties the queue, stops the timer, sets the timeout
// to 22 ticks. The queue RAM itself is not cleared; only queued entries are read.
module stop_and_wait_arq_sender_unit #(
  parameter int QUEUE_DEPTH = sawarq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  sawarq_in_if.sink                           ingress,
  sawarq_out_if.source                        egress,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sawarq_pkg::PADDR_W-1:0]      paddr,
  input  logic [sawarq_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sawarq_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready
);
  import sawarq_pkg::*;

  logic [TIMER_W-1:0] timeout;
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;
  cmd_t  cmd;
  stat_t stat;

  // Register index is the word address.
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_wr && (reg_idx == REG_TIMEOUT)) begin
      timeout <= pwdata[TIMER_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TIMEOUT) prdata = APB_DATA_W'(timeout);
  end

  // Controller: one state per step of an item.
  sawarq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Datapath: capture, checksum, queue RAM, timer and output register.
  sawarq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ingress (ingress),
    .egress  (egress),
    .timeout (timeout),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for stop_and_wait_arq_sender_unit: directed and random item streams.
// Needs sawarq_pkg, sawarq_in_if, sawarq_out_if and the RTL top level.
module tb_top;
  import sawarq_pkg::*;

  // Action code that the block must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int QDEPTH        = DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT   = 1_500_000;
  // Extra wait for the block once every expected packet is out.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 200;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_TIMEOUT  = 65535;
  localparam int LONG_TICKS    = 100;

  typedef enum int {BAD_CHECKSUM, BAD_ACK_NUM, BAD_SEQ} ack_flaw_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ack_seq;
    logic [31:0] ack_number;
    logic [31:0] ack_checksum;
    logic [31:0] hi;
    logic [63:0] mid;
    logic [63:0] lo;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] seq;
    logic [31:0] ack_number;
    logic [31:0] checksum;
    logic [31:0] hi;
    logic [63:0] mid;
    logic [63:0] lo;
  } pkt_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sawarq_in_if  in_ch ();
  sawarq_out_if out_ch ();

  stop_and_wait_arq_sender_unit uut (
    .clk     (clk),
    .rst     (rst),
    .ingress (in_ch),
    .egress  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sender model: packet queue, sequence counter, retransmit timer.
  // ---------------------------------------------------------------------------
  logic [15:0] tmo_reg;
  logic [31:0] seq_next;
  int          q_count;
  int          q_head;
  logic [15:0] tmr_left;
  bit          tmr_on;
  logic [63:0] q_lo  [QDEPTH];
  logic [63:0] q_mid [QDEPTH];
  logic [31:0] q_hi  [QDEPTH];
  logic [31:0] q_chk [QDEPTH];

  pkt_t packets_due[$];   // packets (and drop notices) still to come out

  int     errors;
  int     items_sent;
  int     effective_items;
  int     sent_seen;
  int     drops_seen;
  int     tmo_writes;
  int     idle_pct;
  int     stall_pct;
  longint cycles;

  // Bytes added as signed values, mod 2^32.
  function automatic logic [31:0] signed_byte_sum(logic [159:0] pay);
    logic [31:0] s;
    int          i;
    s = '0;
    for (i = 0; i < PAY_BYTES; i++) s += {{24{pay[8*i+7]}}, pay[8*i +: 8]};
    return s;
  endfunction

  // Everything after the first zero byte is cleared.
  function automatic logic [159:0] clip_at_nul(logic [159:0] pay);
    logic [159:0] r;
    bit           ended;
    int           i;
    r     = '0;
    ended = 1'b0;
    for (i = 0; i < PAY_BYTES; i++) begin
      if (pay[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*i +: 8] = pay[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] front_seq();
    return seq_next - 32'(q_count);
  endfunction

  // Front packet goes out and the timer restarts from the current setting.
  function automatic void send_front();
    pkt_t p;
    p.status     = STATUS_SENT;
    p.seq        = front_seq();
    p.ack_number = ACK_NUM;
    p.checksum   = q_chk[q_head];
    p.hi         = q_hi[q_head];
    p.mid        = q_mid[q_head];
    p.lo         = q_lo[q_head];
    packets_due = {packets_due, p};
    tmr_left = tmo_reg;
    tmr_on   = 1'b1;
  endfunction

  // Applies one accepted item; returns 1 if the item changed anything.
  function automatic bit arq_step(item_t it);
    logic [159:0] pay;
    int           slot;
    pkt_t         drop;
    pay = {it.hi, it.mid, it.lo};
    case (it.action)
      ACT_MSG: begin
        if (q_count >= QDEPTH) begin
          drop        = '0;
          drop.status = STATUS_DROP;
          packets_due = {packets_due, drop};
          return 1'b1;
        end
        pay         = clip_at_nul(pay);
        slot        = (q_head + q_count) % QDEPTH;
        q_lo[slot]  = pay[63:0];
        q_mid[slot] = pay[127:64];
        q_hi[slot]  = pay[159:128];
        q_chk[slot] = seq_next + ACK_NUM + signed_byte_sum(pay);
        seq_next++;
        q_count++;
        if (q_count == 1) send_front();
        return 1'b1;
      end
      ACT_ACK: begin
        if (q_count == 0) return 1'b0;
        if (it.ack_checksum != it.ack_seq + it.ack_number + signed_byte_sum(pay)) return 1'b0;
        if (it.ack_number != ACK_NUM) return 1'b0;
        if (it.ack_seq != front_seq()) return 1'b0;
        tmr_on   = 1'b0;
        tmr_left = '0;
        q_head   = (q_head + 1) % QDEPTH;
        q_count--;
        if (q_count > 0) send_front();
        return 1'b1;
      end
      ACT_TICK: begin
        if (!tmr_on) return 1'b0;
        if (tmr_left > 16'd1) begin
          tmr_left--;
          return 1'b1;
        end
        if (q_count == 0) begin
          tmr_on   = 1'b0;
          tmr_left = '0;
          return 1'b1;
        end
        send_front();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  // Half plain random, half heavy on zero, 0xFF, 0x80 and 0x7F bytes.
  function automatic logic [159:0] random_payload();
    logic [159:0] p;
    int           i;
    int           r;
    bit           plain;
    plain = $urandom_range(0, 1);
    for (i = 0; i < PAY_BYTES; i++) begin
      r = plain ? 15 : $urandom_range(0, 15);
      case (r)
        0:       p[8*i +: 8] = 8'h00;
        1:       p[8*i +: 8] = 8'hFF;
        2:       p[8*i +: 8] = 8'h80;
        3:       p[8*i +: 8] = 8'h7F;
        default: p[8*i +: 8] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  function automatic logic [31:0] nonzero_word();
    logic [31:0] d;
    d = $urandom;
    if (d == '0) d = 32'd1;
    return d;
  endfunction

  function automatic item_t noise_item(logic [1:0] act);
    item_t it;
    it.action       = act;
    it.ack_seq      = $urandom;
    it.ack_number   = $urandom;
    it.ack_checksum = $urandom;
    {it.hi, it.mid, it.lo} = random_payload();
    return it;
  endfunction

  function automatic item_t make_msg(logic [159:0] pay);
    item_t it;
    it = noise_item(ACT_MSG);
    {it.hi, it.mid, it.lo} = pay;
    return it;
  endfunction

  // Ack for the current front packet; a flawed one breaks exactly one check.
  function automatic item_t make_ack(bit good, ack_flaw_t flaw);
    item_t it;
    it            = noise_item(ACT_ACK);
    it.ack_seq    = front_seq();
    it.ack_number = ACK_NUM;
    if (!good && flaw == BAD_ACK_NUM)
      while (it.ack_number == ACK_NUM) it.ack_number = $urandom;
    if (!good && flaw == BAD_SEQ) it.ack_seq = front_seq() + nonzero_word();
    it.ack_checksum = it.ack_seq + it.ack_number + signed_byte_sum({it.hi, it.mid, it.lo});
    if (!good && flaw == BAD_CHECKSUM) it.ack_checksum += nonzero_word();
    return it;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Presents one item (after a random idle stretch) and holds it until taken.
  task automatic send_item(item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.action       = it.action;
    in_ch.ack_seq      = it.ack_seq;
    in_ch.ack_number   = it.ack_number;
    in_ch.ack_checksum = it.ack_checksum;
    in_ch.payload_low  = it.lo;
    in_ch.payload_mid  = it.mid;
    in_ch.payload_high = it.hi;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (arq_step(it)) effective_items++;
  endtask

  // Stop feeding, wait for every expected packet, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (packets_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB read of the timeout register, compared with the model's copy.
  task automatic check_timeout_reg();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {REG_TIMEOUT, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== tmo_reg)
      flag_error($sformatf("timeout register read %h, expected %h", prdata[15:0], tmo_reg));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Only called with the block idle. Upper data bits are junk on purpose.
  task automatic set_timeout(logic [15:0] value);
    logic [APB_DATA_W-1:0] data;
    drain();
    data       = $urandom;
    data[15:0] = value;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_TIMEOUT, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tmo_reg = value;
    tmo_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_timeout_reg();
  endtask

  // Egress backpressure, redrawn every cycle.
  always @(negedge clk) out_ch.ready = ($urandom_range(0, 99) >= stall_pct);

  // ---------------------------------------------------------------------------
  // Result checker: every egress item against the oldest expected packet.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pkt_t got;
    pkt_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.status, out_ch.out_seq, out_ch.out_ack_number, out_ch.out_checksum,
             out_ch.out_payload_high, out_ch.out_payload_mid, out_ch.out_payload_low};
      if (got.status == STATUS_DROP) drops_seen++;
      else sent_seen++;
      if (packets_due.size() == 0) begin
        flag_error($sformatf("unexpected item st=%b seq=%h chk=%h", got.status, got.seq,
                             got.checksum));
      end else begin
        want = packets_due.pop_front();
        if (got !== want)
          flag_error($sformatf({"item %0d mismatch\n  exp st=%b seq=%h ack=%h chk=%h ",
                                "pay=%h_%h_%h\n  got st=%b seq=%h ack=%h chk=%h pay=%h_%h_%h"},
                               sent_seen + drops_seen,
                               want.status, want.seq, want.ack_number, want.checksum,
                               want.hi, want.mid, want.lo,
                               got.status, got.seq, got.ack_number, got.checksum,
                               got.hi, got.mid, got.lo));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d items still due", cycles,
               packets_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Timeout register comes out of reset at its default.
  task automatic test_reset_value();
    check_timeout_reg();
  endtask

  // Empty queue: tick with the timer stopped, ack with nothing queued, unused action.
  task automatic test_ignored_items();
    send_item(noise_item(ACT_TICK));
    send_item(make_ack(1'b1, BAD_CHECKSUM));
    send_item(noise_item(ACT_UNUSED));
  endtask

  // First send, the three ack rejections, and payload clipping / sign handling.
  task automatic test_send_and_bad_acks();
    logic [159:0] pay;
    int           i;
    send_item(make_msg({160{1'b1}}));          // all bytes -1, goes out at once
    send_item(make_ack(1'b0, BAD_CHECKSUM));
    send_item(make_ack(1'b0, BAD_ACK_NUM));
    send_item(make_ack(1'b0, BAD_SEQ));
    pay        = {160{1'b1}};
    pay[7:0]   = 8'h00;                        // zero first byte clears everything
    send_item(make_msg(pay));
    for (i = 0; i < PAY_BYTES; i++) pay[8*i +: 8] = i[0] ? 8'h7F : 8'h80;
    pay[159:152] = 8'h00;                      // zero only in the last byte
    send_item(make_msg(pay));
    send_item(make_msg('0));
    for (i = 0; i < PAY_BYTES; i++) pay[8*i +: 8] = 8'($urandom_range(1, 255));
    pay[87:80] = 8'h00;                        // zero in the middle
    send_item(make_msg(pay));
  endtask

  // Expiry after two ticks, a zero setting (acts as one), and a setting of one.
  task automatic test_timer_expiry();
    set_timeout(16'd2);
    send_item(make_ack(1'b1, BAD_CHECKSUM));
    send_item(noise_item(ACT_TICK));
    send_item(noise_item(ACT_TICK));
    set_timeout(16'd0);
    send_item(make_ack(1'b1, BAD_CHECKSUM));
    send_item(noise_item(ACT_TICK));
    set_timeout(16'd1);
    send_item(make_ack(1'b1, BAD_CHECKSUM));
    send_item(noise_item(ACT_TICK));
  endtask

  // Largest timeout: a run of ticks counts down from the top without a resend.
  task automatic test_long_timeout();
    idle_pct  = 0;
    stall_pct = 0;
    while (q_count > 0) send_item(make_ack(1'b1, BAD_CHECKSUM));
    set_timeout(16'(LONG_TIMEOUT));
    send_item(make_msg(random_payload()));
    repeat (LONG_TICKS) send_item(noise_item(ACT_TICK));
    send_item(make_ack(1'b1, BAD_CHECKSUM));
  endtask

  // Mostly legal traffic with a tunable message share, plus rejected acks and noise.
  task automatic test_random(int idle, int stall, logic [15:0] tmo, int msg_w);
    int start;
    int r;
    idle_pct  = idle;
    stall_pct = stall;
    set_timeout(tmo);
    start = effective_items;
    while (effective_items - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < msg_w)           send_item(make_msg(random_payload()));
      else if (r < msg_w + 25) send_item(make_ack(1'b1, BAD_CHECKSUM));
      else if (r < msg_w + 32) send_item(make_ack(1'b0, ack_flaw_t'($urandom_range(0, 2))));
      else if (r < msg_w + 35) send_item(noise_item(ACT_UNUSED));
      else if (r < msg_w + 38) send_item(noise_item(ACT_ACK));
      else                     send_item(noise_item(ACT_TICK));
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_MSG;
    in_ch.ack_seq      = '0;
    in_ch.ack_number   = '0;
    in_ch.ack_checksum = '0;
    in_ch.payload_low  = '0;
    in_ch.payload_mid  = '0;
    in_ch.payload_high = '0;
    out_ch.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    // model state after reset
    tmo_reg   = TIMEOUT_RESET;
    seq_next  = '0;
    q_count   = 0;
    q_head    = 0;
    tmr_left  = '0;
    tmr_on    = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_value();
    test_ignored_items();
    test_send_and_bad_acks();
    test_timer_expiry();
    test_long_timeout();
    test_random(0, 0, 16'd3, 40);
    test_random(76, 0, 16'd1, 30);
    test_random(0, 76, 16'($urandom_range(2, 8)), 45);
    test_random(38, 38, 16'd5, 20);
    drain();

    $display("Covered %0d items (%0d with effect), %0d timeout writes incl. 0, 1 and %0d.",
             items_sent, effective_items, tmo_writes, LONG_TIMEOUT);
    $display("Checked %0d sent packets and %0d drops; %0d errors.", sent_seen, drops_seen,
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
